// File: rtl/core/nrr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrr_pkg
// Shared types and constants of the node registration responder.
// ----------------------------------------------------------------------------
package nrr_pkg;

	localparam int TABLE_SLOTS_DEF     = 16;
	localparam int FRAME_OVERHEAD_DEF  = 11;
	localparam int FRAME_MAX_BYTES_DEF = 31;

	localparam int CMD_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	localparam int POS_W = 5;
	localparam logic [POS_W-1:0] POS_MAX = 5'd31;

	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_OWN_ID            = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAKER_CODE        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CODE_HELLO_HUB    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CODE_HUB_MY_HUB   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CODE_HELLO_NODE   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CODE_NODE_MY_NODE = 3'd5;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       rx_end;
	} rx_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_end;
	} tx_item_t;

	typedef struct packed {
		logic [31:0] own_id;
		logic [15:0] maker_code;
		logic [31:0] code_hello_hub;
		logic [31:0] code_hub_my_hub;
		logic [31:0] code_hello_node;
		logic [31:0] code_node_my_node;
	} cfg_regs_t;

	typedef enum logic {
		CMD_HELLO,
		CMD_REGISTER
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] sid;
	} cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/node_registration_responder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// node_registration_responder
// Parses received packets, keeps the node table and emits answer frames.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle while the two-entry command queue
// has room; full rises only when two packets that need action wait behind the
// back end. The back end handles one command at a time: a registration scans the
// node table slot by slot (registered table read, then compare), and an
// answer frame of min(FRAME_OVERHEAD+4, FRAME_MAX_BYTES) bytes leaves at one
// byte per cycle while the four-entry result queue has room. Configuration
// writes are always ready.
module node_registration_responder #(
	parameter int TABLE_SLOTS     = nrr_pkg::TABLE_SLOTS_DEF,
	parameter int FRAME_OVERHEAD  = nrr_pkg::FRAME_OVERHEAD_DEF,
	parameter int FRAME_MAX_BYTES = nrr_pkg::FRAME_MAX_BYTES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire nrr_pkg::rx_item_t                  rx_item,
	input  wire logic                               pop,
	output logic                                    empty,
	output nrr_pkg::tx_item_t                       tx_item,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [nrr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [31:0]                        cfg_data
);
	import nrr_pkg::*;

	cfg_regs_t regs_q;
	logic      accept;
	logic      cmd_push;
	cmd_t      cmd_in;
	logic      cmd_full;
	logic      cmd_empty;
	logic      cmd_pop;
	logic [$bits(cmd_t)-1:0] cmd_bits;
	cmd_t      cmd_out;
	logic      out_full;
	logic      out_push;
	tx_item_t  out_item;
	logic [$bits(tx_item_t)-1:0] tx_bits;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full;
	assign accept    = push && !full;
	assign cmd_out   = cmd_t'(cmd_bits);
	assign tx_item   = tx_item_t'(tx_bits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OWN_ID:            regs_q.own_id            <= cfg_data;
				REG_MAKER_CODE:        regs_q.maker_code        <= cfg_data[15:0];
				REG_CODE_HELLO_HUB:    regs_q.code_hello_hub    <= cfg_data;
				REG_CODE_HUB_MY_HUB:   regs_q.code_hub_my_hub   <= cfg_data;
				REG_CODE_HELLO_NODE:   regs_q.code_hello_node   <= cfg_data;
				REG_CODE_NODE_MY_NODE: regs_q.code_node_my_node <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	nrr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_item  (rx_item),
		.regs     (regs_q),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	nrr_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_bits),
		.full    (cmd_full),
		.empty   (cmd_empty)
	);

	nrr_back #(
		.TABLE_SLOTS     (TABLE_SLOTS),
		.FRAME_OVERHEAD  (FRAME_OVERHEAD),
		.FRAME_MAX_BYTES (FRAME_MAX_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs_q),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (out_item)
	);

	nrr_fifo #(
		.WIDTH ($bits(tx_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_item),
		.rd_en   (pop),
		.rd_data (tx_bits),
		.full    (out_full),
		.empty   (empty)
	);

	a_cmd_on_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (accept && rx_item.rx_end))
		else $error("command issued without an accepted final byte");

	a_no_cmd_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command queue overflow");

	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result queue overflow");

endmodule
`default_nettype wire

// File: rtl/core/nrr_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrr_fifo
// Small register FIFO used for the command queue and the result queue.
// ----------------------------------------------------------------------------
module nrr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/nrr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrr_front
// Packet parser: gathers source ID and message code, tracks the learn mode
// and issues one command per packet that needs an answer or a table update.
// ----------------------------------------------------------------------------
module nrr_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire nrr_pkg::rx_item_t rx_item,
	input  wire nrr_pkg::cfg_regs_t regs,
	output logic                   cmd_push,
	output nrr_pkg::cmd_t          cmd
);
	import nrr_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [31:0]      sid_q;
	logic [31:0]      code_q;
	logic             learning_q;
	logic [31:0]      sid_nx;
	logic [31:0]      code_nx;
	logic             msg_done;
	logic             is_hello;
	logic             is_confirm;

	always_comb begin
		sid_nx  = sid_q;
		code_nx = code_q;
		if (pos_q inside {[5'd6:5'd9]}) begin
			sid_nx = {sid_q[23:0], rx_item.rx_byte};
		end else if (pos_q inside {[5'd14:5'd17]}) begin
			code_nx = {code_q[23:0], rx_item.rx_byte};
		end
	end

	// hello-hub wins when both codes are equal
	assign msg_done   = accept && rx_item.rx_end && (pos_q >= 5'd17);
	assign is_hello   = (code_nx == regs.code_hello_hub);
	assign is_confirm = !is_hello && (code_nx == regs.code_hub_my_hub);

	assign cmd_push = msg_done && ((is_hello && !learning_q) || (is_confirm && learning_q));
	assign cmd.kind = is_hello ? CMD_HELLO : CMD_REGISTER;
	assign cmd.sid  = sid_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			sid_q      <= '0;
			code_q     <= '0;
			learning_q <= 1'b0;
		end else if (accept) begin
			sid_q  <= sid_nx;
			code_q <= code_nx;
			if (rx_item.rx_end) begin
				pos_q <= '0;
			end else if (pos_q != POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
			if (msg_done) begin
				if (is_hello && !learning_q) begin
					learning_q <= 1'b1;
				end else if (is_confirm && learning_q) begin
					learning_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/nrr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrr_back
// Command executor: scans and updates the node table on a registration, and
// streams the frame one byte per cycle when not stalled, with a running XOR checksum.
// ----------------------------------------------------------------------------
module nrr_back #(
	parameter int TABLE_SLOTS     = nrr_pkg::TABLE_SLOTS_DEF,
	parameter int FRAME_OVERHEAD  = nrr_pkg::FRAME_OVERHEAD_DEF,
	parameter int FRAME_MAX_BYTES = nrr_pkg::FRAME_MAX_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire nrr_pkg::cfg_regs_t regs,
	input  wire logic               cmd_empty,
	input  wire nrr_pkg::cmd_t      cmd,
	output logic                    cmd_pop,
	input  wire logic               out_full,
	output logic                    out_push,
	output nrr_pkg::tx_item_t       out_item
);
	import nrr_pkg::*;

	localparam int IW           = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int FRAME_WANTED = FRAME_OVERHEAD + 4;
	localparam int FRAME_LEN    = (FRAME_WANTED < FRAME_MAX_BYTES) ? FRAME_WANTED
	                                                               : FRAME_MAX_BYTES;
	localparam logic [POS_W-1:0] LAST_K = POS_W'(FRAME_LEN - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [31:0]      sid_q;
	logic [31:0]      code_q;
	logic [IW-1:0]    idx_q;
	logic [POS_W-1:0] k_q;
	logic [7:0]       sum_q;
	logic [31:0]      tbl_mem [TABLE_SLOTS];
	logic [31:0]      tbl_rd_q;
	logic             tbl_vld_q [TABLE_SLOTS];
	logic             vld_rd_q;
	logic [31:0]      entry;
	logic             tbl_we;
	logic [7:0]       hdr_byte;

	assign entry   = vld_rd_q ? tbl_rd_q : 32'd0;
	assign tbl_we  = (state_q == ST_SCAN_CMP) && (entry != sid_q) && (entry == 32'd0);
	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty;

	always_comb begin
		case (k_q)
			5'd0:    hdr_byte = regs.maker_code[15:8];
			5'd1:    hdr_byte = regs.maker_code[7:0];
			5'd2:    hdr_byte = regs.own_id[31:24];
			5'd3:    hdr_byte = regs.own_id[23:16];
			5'd4:    hdr_byte = regs.own_id[15:8];
			5'd5:    hdr_byte = regs.own_id[7:0];
			5'd6:    hdr_byte = sid_q[31:24];
			5'd7:    hdr_byte = sid_q[23:16];
			5'd8:    hdr_byte = sid_q[15:8];
			5'd9:    hdr_byte = sid_q[7:0];
			5'd10:   hdr_byte = code_q[31:24];
			5'd11:   hdr_byte = code_q[23:16];
			5'd12:   hdr_byte = code_q[15:8];
			5'd13:   hdr_byte = code_q[7:0];
			default: hdr_byte = 8'h00;
		endcase
	end

	assign out_push         = (state_q == ST_EMIT) && !out_full;
	assign out_item.tx_end  = (k_q == LAST_K);
	assign out_item.tx_byte = (k_q == LAST_K) ? sum_q : hdr_byte;

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[idx_q] <= sid_q;
		end
		tbl_rd_q <= tbl_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				tbl_vld_q[i] <= 1'b0;
			end
			vld_rd_q <= 1'b0;
		end else begin
			if (tbl_we) begin
				tbl_vld_q[idx_q] <= 1'b1;
			end
			vld_rd_q <= tbl_vld_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sid_q   <= '0;
			code_q  <= '0;
			idx_q   <= '0;
			k_q     <= '0;
			sum_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						sid_q <= cmd.sid;
						idx_q <= '0;
						k_q   <= '0;
						sum_q <= '0;
						if (cmd.kind == CMD_HELLO) begin
							code_q  <= regs.code_hello_node;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_SCAN_RD;
						end
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CMP;
				end
				ST_SCAN_CMP: begin
					if (entry == sid_q) begin
						state_q <= ST_IDLE;
					end else if (entry == 32'd0) begin
						code_q  <= regs.code_node_my_node;
						state_q <= ST_EMIT;
					end else if (idx_q == IW'(TABLE_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_EMIT: begin
					if (!out_full) begin
						sum_q <= sum_q ^ hdr_byte;
						k_q   <= k_q + 1'b1;
						if (k_q == LAST_K) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
